@@ rtl/ghdc_pkg.sv @@
// Shared constants, types and codes for the glyph halo colorizer.
`timescale 1ns / 1ps

package ghdc_pkg;

  // Mask area limits; the input coordinate fields are sized to match them.
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 128;
  localparam int MAX_HALO   = 15;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int HW = (MAX_HALO > 0) ? $clog2(MAX_HALO + 1) : 1;

  // Configuration register widths.
  localparam int WREG_W = 10;
  localparam int HREG_W = 8;
  localparam int TREG_W = 4;
  localparam int RGBA_W = 32;
  localparam int DATA_W = 32;
  localparam int CFG_AW = 5;
  localparam int IDX_W  = CFG_AW - 2;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_THICK  = 3'd2;
  localparam logic [IDX_W-1:0] REG_FG     = 3'd3;
  localparam logic [IDX_W-1:0] REG_HALO   = 3'd4;
  localparam logic [IDX_W-1:0] REG_BG     = 3'd5;

  // Pixel class codes.
  localparam logic [1:0] CLS_BG   = 2'd0;
  localparam logic [1:0] CLS_FG   = 2'd1;
  localparam logic [1:0] CLS_HALO = 2'd2;

  // Access function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Effective configuration seen by the sequencer.
  typedef struct packed {
    logic [WREG_W-1:0] width;
    logic [HREG_W-1:0] height;
    logic [HW-1:0]     thick;
    logic [RGBA_W-1:0] fg;
    logic [RGBA_W-1:0] halo;
    logic [RGBA_W-1:0] bg;
  } cfg_t;

  // Requests from the sequencer to the mask memory.
  typedef struct packed {
    logic          wr_en;
    logic [YW-1:0] wr_row;
    logic [XW-1:0] wr_col;
    logic          wr_bit;
    logic          rd_en;
    logic [YW-1:0] rd_row;
  } mem_req_t;

endpackage

@@ rtl/ghdc_cfg.sv @@
// Configuration registers with an APB-style write and read port.
`timescale 1ns / 1ps

module ghdc_cfg import ghdc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [WREG_W-1:0] width_r;
  logic [HREG_W-1:0] height_r;
  logic [TREG_W-1:0] thick_r;
  logic [RGBA_W-1:0] fg_r;
  logic [RGBA_W-1:0] halo_r;
  logic [RGBA_W-1:0] bg_r;
  logic              wr_c;
  logic [IDX_W-1:0]  idx_c;

  assign pready = 1'b1;
  assign wr_c   = psel && penable && pwrite && pready;
  assign idx_c  = paddr[CFG_AW-1:2];

  // Register writes; unlisted addresses are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WREG_W'(MAX_WIDTH);
      height_r <= HREG_W'(MAX_HEIGHT);
      thick_r  <= '0;
      fg_r     <= 32'hFFFF_FFFF;
      halo_r   <= 32'h0000_00FF;
      bg_r     <= '0;
    end else if (wr_c) begin
      unique case (idx_c)
        REG_WIDTH:  width_r  <= pwdata[WREG_W-1:0];
        REG_HEIGHT: height_r <= pwdata[HREG_W-1:0];
        REG_THICK:  thick_r  <= pwdata[TREG_W-1:0];
        REG_FG:     fg_r     <= pwdata[RGBA_W-1:0];
        REG_HALO:   halo_r   <= pwdata[RGBA_W-1:0];
        REG_BG:     bg_r     <= pwdata[RGBA_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back of the stored register values.
  always_comb begin
    unique case (idx_c)
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      REG_THICK:  prdata = DATA_W'(thick_r);
      REG_FG:     prdata = DATA_W'(fg_r);
      REG_HALO:   prdata = DATA_W'(halo_r);
      REG_BG:     prdata = DATA_W'(bg_r);
      default:    prdata = '0;
    endcase
  end

  // Sizes clamp to the mask area and the radius saturates.
  always_comb begin
    cfg.width  = (width_r > WREG_W'(MAX_WIDTH)) ? WREG_W'(MAX_WIDTH) : width_r;
    cfg.height = (height_r > HREG_W'(MAX_HEIGHT)) ? HREG_W'(MAX_HEIGHT) : height_r;
    cfg.thick  = (32'(thick_r) > MAX_HALO) ? HW'(MAX_HALO) : HW'(thick_r);
    cfg.fg     = fg_r;
    cfg.halo   = halo_r;
    cfg.bg     = bg_r;
  end

endmodule

@@ rtl/ghdc_mask_mem.sv @@
// Row-packed glyph mask memory: one bit written, one whole row read per cycle.
`timescale 1ns / 1ps

module ghdc_mask_mem import ghdc_pkg::*; (
  input  logic                 clk,
  input  mem_req_t             req,
  output logic [MAX_WIDTH-1:0] rd_data
);

  logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];

  // Single-bit write into a row and registered row read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row][req.wr_col] <= req.wr_bit;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_row];
    end
  end

endmodule

@@ rtl/ghdc_seq.sv @@
// Access sequencer: row scan over the halo window and the result register.
`timescale 1ns / 1ps

module ghdc_seq import ghdc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [XW-1:0]        in_x_pos,
  input  logic [YW-1:0]        in_y_pos,
  input  logic                 in_mask_bit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic [7:0]           out_alpha,
  output logic [1:0]           out_pixel_class,
  output logic                 out_out_of_range,
  output mem_req_t             mem_req,
  input  logic [MAX_WIDTH-1:0] rd_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BOUND = 6'b000010,
    S_MASK  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [XW-1:0]        x_r, x_nxt;
  logic [YW-1:0]        y_r, y_nxt;
  logic                 oor_r, oor_nxt;
  logic [YW-1:0]        ylo_r, ylo_nxt, yhi_r, yhi_nxt;
  logic [XW-1:0]        xlo_r, xlo_nxt, xhi_r, xhi_nxt;
  logic [MAX_WIDTH-1:0] mask_r, mask_nxt;
  logic [YW-1:0]        row_r, row_nxt;
  logic                 pend_r, pend_nxt;
  logic                 pend_ctr_r, pend_ctr_nxt;
  logic                 hit_r, hit_nxt;
  logic                 ctr_r, ctr_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [RGBA_W-1:0]    out_rgba_r, out_rgba_nxt;
  logic [1:0]           out_cls_r, out_cls_nxt;
  logic                 out_oor_r, out_oor_nxt;

  logic                 in_acc;
  logic                 oor_c;
  logic [HREG_W-1:0]    yt_c, hm1_c;
  logic [WREG_W-1:0]    xt_c, wm1_c;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign oor_c    = (WREG_W'(in_x_pos) >= cfg.width) || (HREG_W'(in_y_pos) >= cfg.height);

  // Window edges before clipping to the image.
  assign yt_c  = HREG_W'(y_r) + HREG_W'(cfg.thick);
  assign xt_c  = WREG_W'(x_r) + WREG_W'(cfg.thick);
  assign hm1_c = cfg.height - HREG_W'(1);
  assign wm1_c = cfg.width - WREG_W'(1);

  // In-range writes go to the memory at the accepting edge.
  always_comb begin
    mem_req.wr_en  = in_acc && (in_func == FUNC_WRITE) && !oor_c;
    mem_req.wr_row = in_y_pos;
    mem_req.wr_col = in_x_pos;
    mem_req.wr_bit = in_mask_bit;
    mem_req.rd_en  = (state_r == S_SCAN);
    mem_req.rd_row = row_r;
  end

  // Sequencer and window accumulation.
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    oor_nxt       = oor_r;
    ylo_nxt       = ylo_r;
    yhi_nxt       = yhi_r;
    xlo_nxt       = xlo_r;
    xhi_nxt       = xhi_r;
    mask_nxt      = mask_r;
    row_nxt       = row_r;
    pend_nxt      = 1'b0;
    pend_ctr_nxt  = 1'b0;
    hit_nxt       = hit_r;
    ctr_nxt       = ctr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rgba_nxt  = out_rgba_r;
    out_cls_nxt   = out_cls_r;
    out_oor_nxt   = out_oor_r;

    // A row read last cycle is now on the memory output.
    if (pend_r) begin
      hit_nxt = hit_r || (|(rd_data & mask_r));
      if (pend_ctr_r) begin
        ctr_nxt = rd_data[x_r];
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_nxt   = in_x_pos;
          y_nxt   = in_y_pos;
          oor_nxt = oor_c;
          if (oor_c) begin
            state_nxt = S_DONE;
          end else if (in_func == FUNC_READ) begin
            state_nxt = S_BOUND;
          end
        end
      end
      S_BOUND: begin
        ylo_nxt   = (HREG_W'(y_r) >= HREG_W'(cfg.thick)) ?
                    YW'(HREG_W'(y_r) - HREG_W'(cfg.thick)) : '0;
        yhi_nxt   = (yt_c > hm1_c) ? YW'(hm1_c) : YW'(yt_c);
        xlo_nxt   = (WREG_W'(x_r) >= WREG_W'(cfg.thick)) ?
                    XW'(WREG_W'(x_r) - WREG_W'(cfg.thick)) : '0;
        xhi_nxt   = (xt_c > wm1_c) ? XW'(wm1_c) : XW'(xt_c);
        state_nxt = S_MASK;
      end
      S_MASK: begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
          mask_nxt[i] = (XW'(i) >= xlo_r) && (XW'(i) <= xhi_r);
        end
        row_nxt   = ylo_r;
        hit_nxt   = 1'b0;
        ctr_nxt   = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        pend_nxt     = 1'b1;
        pend_ctr_nxt = (row_r == y_r);
        if (row_r == yhi_r) begin
          state_nxt = S_DRAIN;
        end else begin
          row_nxt = row_r + YW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_oor_nxt   = oor_r;
          if (oor_r) begin
            out_rgba_nxt = '0;
            out_cls_nxt  = CLS_BG;
          end else if (ctr_r) begin
            out_rgba_nxt = cfg.fg;
            out_cls_nxt  = CLS_FG;
          end else if (hit_r) begin
            out_rgba_nxt = cfg.halo;
            out_cls_nxt  = CLS_HALO;
          end else begin
            out_rgba_nxt = cfg.bg;
            out_cls_nxt  = CLS_BG;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    oor_r      <= oor_nxt;
    ylo_r      <= ylo_nxt;
    yhi_r      <= yhi_nxt;
    xlo_r      <= xlo_nxt;
    xhi_r      <= xhi_nxt;
    mask_r     <= mask_nxt;
    row_r      <= row_nxt;
    pend_ctr_r <= pend_ctr_nxt;
    hit_r      <= hit_nxt;
    ctr_r      <= ctr_nxt;
    out_rgba_r <= out_rgba_nxt;
    out_cls_r  <= out_cls_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_red          = out_rgba_r[31:24];
  assign out_green        = out_rgba_r[23:16];
  assign out_blue         = out_rgba_r[15:8];
  assign out_alpha        = out_rgba_r[7:0];
  assign out_pixel_class  = out_cls_r;
  assign out_out_of_range = out_oor_r;

endmodule

@@ rtl/glyph_halo_dilate_colorize_core.sv @@
// Top level of the glyph halo colorizer: registers, sequencer and mask memory.
//
//   Channel  Direction  Handshake               Payload
//   in_      input      in_valid / in_stall     func, x_pos, y_pos, mask_bit
//   out_     output     out_valid / out_stall   red, green, blue, alpha, pixel_class,
//                                               out_of_range
//   cfg      input      psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// An in-range write gives no item. An out-of-range access goes straight to S_DONE.
// A read goes through S_BOUND, S_MASK, S_SCAN, S_DRAIN and S_DONE; S_SCAN reads the
// window rows inside the image (at most 2 * MAX_HALO + 1) in turn through the single
// row read port of the mask memory. Reset (rst_n low, synchronous) clears control
// state and restores register defaults; the mask memory is not cleared. The result
// register holds an item while out_stall is high and input is accepted meanwhile, but
// an access that gives an item waits in S_DONE, with in_stall high, until it is free.
`timescale 1ns / 1ps

module glyph_halo_dilate_colorize_core import ghdc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  logic [XW-1:0]     in_x_pos,
  input  logic [YW-1:0]     in_y_pos,
  input  logic              in_mask_bit,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_alpha,
  output logic [1:0]        out_pixel_class,
  output logic              out_out_of_range,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t                 cfg;
  mem_req_t             mem_req;
  logic [MAX_WIDTH-1:0] rd_data;

  // Configuration registers.
  ghdc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Access sequencer.
  ghdc_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_x_pos         (in_x_pos),
    .in_y_pos         (in_y_pos),
    .in_mask_bit      (in_mask_bit),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_pixel_class  (out_pixel_class),
    .out_out_of_range (out_out_of_range),
    .mem_req          (mem_req),
    .rd_data          (rd_data)
  );

  // Glyph mask storage.
  ghdc_mask_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule
